// File: hw/rtl/tksm_pkg.sv
// Package for the top-k sum times min key score engine.
// Holds sizing constants and controller command/status structs.
package tksm_pkg;
   localparam int MaxPairsDefault  = 1024;
   localparam int ValueBitsDefault = 16;
   localparam int CountBits        = 11;
   localparam int ScoreBits        = 42;

   typedef struct packed {
      logic load;       // write incoming pair at pair_count
      logic clr_count;  // return pair count to zero
      logic sort_rd;    // read store[j-1]
      logic sort_cur;   // capture store[i] as cur
      logic init_i;     // begin outer step i, read store[i]
      logic shift_wr;   // store[j] <= store[j-1], j--
      logic place_wr;   // store[j] <= cur
      logic scan_init;  // reset heap/sum/best, i = 0
      logic scan_rd;    // read store[i]
      logic hp_push;    // append weight at heap end
      logic hp_put;     // write moving weight at pos
      logic hp_up_rd;   // read heap parent
      logic hp_up_sw;   // move parent down into pos
      logic hp_rep;     // replace root with weight
      logic hp_dn_rd;   // read left child
      logic hp_dn_rd2;  // take left child, read right child
      logic hp_dn_rd3;  // take right child
      logic hp_dn_sw;   // move smaller child up into pos
      logic score;      // form product
      logic accum;      // update best
      logic next_i;     // advance scan index
      logic emit;       // present result
   } tksm_cmd_type;

   typedef struct packed {
      logic bad;
      logic full;
      logic sort_more;   // i < n
      logic shift_go;    // j>0 && store[j-1] < cur
      logic scan_more;   // i < n
      logic heap_fill;   // heap_size < k
      logic up_go;       // parent > moving weight
      logic up_top;      // pos == 0
      logic dn_has_l;
      logic dn_has_r;
      logic dn_go;       // a child is smaller than the moving weight
      logic at_k;        // heap_size == k
   } tksm_sts_type;
endpackage

// File: hw/rtl/tksm_ram.sv
// Generic simple dual-port RAM with registered read, one write port.
// No dependencies.
module tksm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule

// File: hw/rtl/tksm_datapath.sv
// Datapath: pair store, weight heap, sort and heap indices, sum and score.
// Depends on tksm_pkg and tksm_ram.
module tksm_datapath import tksm_pkg::*; #(
   parameter int MaxPairs  = MaxPairsDefault,
   parameter int ValueBits = ValueBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tksm_cmd_type           cmd,
   output tksm_sts_type           sts,
   input  logic [ValueBits-1:0]   weight,
   input  logic [ValueBits-1:0]   key,
   input  logic [CountBits-1:0]   keep_count,
   output logic [ScoreBits-1:0]   score,
   output logic                   bad_count
);
   localparam int AW = $clog2(MaxPairs);
   localparam int CW = AW + 1;
   localparam int PW = 2 * ValueBits;
   localparam int SW = ValueBits + CW;
   localparam int BW = SW + ValueBits;
   localparam int KW = (CW > CountBits) ? CW : CountBits;

   logic [CW-1:0] count_ff, i_ff, j_ff, hsize_ff, pos_ff, m_ff;
   logic [PW-1:0] cur_ff;
   logic [ValueBits-1:0] w_ff, lv_ff;
   logic [SW-1:0] sum_ff;
   logic [BW-1:0] prod_ff, best_ff;
   logic [CW-1:0] kext;
   logic          full;

   // store port
   logic          s_we;
   logic [AW-1:0] s_wa, s_ra;
   logic [PW-1:0] s_wd, s_rd;
   // heap port
   logic          h_we;
   logic [AW-1:0] h_wa, h_ra;
   logic [ValueBits-1:0] h_wd, h_rd;

   tksm_ram #(.Width(PW), .Depth(MaxPairs)) u_store (
      .clock, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
   tksm_ram #(.Width(ValueBits), .Depth(MaxPairs)) u_heap (
      .clock, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

   assign kext = CW'(keep_count);
   assign full = count_ff == CW'(MaxPairs);

   logic [CW-1:0] parent, lchild, rchild;
   assign parent = (pos_ff - CW'(1)) >> 1;
   assign lchild = CW'({pos_ff, 1'b1});
   assign rchild = lchild + CW'(1);

   always_comb begin
      s_we = 1'b0; s_wa = count_ff[AW-1:0]; s_wd = {key, weight};
      s_ra = i_ff[AW-1:0];
      if (cmd.load) s_we = !full;
      if (cmd.sort_rd) s_ra = AW'(j_ff - CW'(1));
      // s_rd holds store[j-1] here, read in the previous cycle
      if (cmd.shift_wr) begin s_we = 1'b1; s_wa = j_ff[AW-1:0]; s_wd = s_rd; end
      if (cmd.place_wr) begin s_we = 1'b1; s_wa = j_ff[AW-1:0]; s_wd = cur_ff; end
      if (cmd.init_i) s_ra = i_ff[AW-1:0];
      h_we = 1'b0; h_wa = pos_ff[AW-1:0]; h_wd = w_ff; h_ra = pos_ff[AW-1:0];
      if (cmd.hp_push) begin h_we = 1'b1; h_wa = hsize_ff[AW-1:0]; end
      if (cmd.hp_rep) begin h_we = 1'b1; h_wa = '0; end
      if (cmd.hp_put) h_we = 1'b1;
      if (cmd.hp_up_rd) h_ra = parent[AW-1:0];
      if (cmd.hp_dn_rd) h_ra = lchild[AW-1:0];
      if (cmd.hp_dn_rd2) h_ra = rchild[AW-1:0];
      // swap: the neighbor moves into pos, the moving weight follows via hp_put
      if (cmd.hp_up_sw) begin h_we = 1'b1; h_wa = pos_ff[AW-1:0]; h_wd = h_rd; end
      if (cmd.hp_dn_sw) begin h_we = 1'b1; h_wa = pos_ff[AW-1:0]; h_wd = lv_ff; end
   end

   // w_ff is the moving weight; lv_ff holds the smallest child seen
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         if (cmd.load && !full) count_ff <= count_ff + CW'(1);
         if (cmd.clr_count) count_ff <= '0;
      end
      if (cmd.scan_init) begin
         i_ff <= '0; hsize_ff <= '0; sum_ff <= '0; best_ff <= '0;
      end
      if (cmd.init_i) begin
         j_ff <= i_ff;
      end
      if (cmd.sort_cur) cur_ff <= s_rd;
      if (cmd.shift_wr) j_ff <= j_ff - CW'(1);
      if (cmd.place_wr) i_ff <= i_ff + CW'(1);
      if (cmd.scan_rd) begin
         w_ff <= s_rd[ValueBits-1:0];
         cur_ff <= s_rd;
         pos_ff <= '0;
      end
      if (cmd.hp_push) begin
         pos_ff <= hsize_ff; hsize_ff <= hsize_ff + CW'(1);
         sum_ff <= sum_ff + SW'(w_ff);
      end
      if (cmd.hp_up_rd) m_ff <= parent;
      if (cmd.hp_up_sw) pos_ff <= m_ff;
      if (cmd.hp_rep) begin
         pos_ff <= '0;
         sum_ff <= sum_ff - SW'(h_rd) + SW'(w_ff);
      end
      if (cmd.hp_dn_rd) m_ff <= pos_ff;
      if (cmd.hp_dn_rd2) begin
         if (h_rd < w_ff) begin m_ff <= lchild; lv_ff <= h_rd; end
      end
      if (cmd.hp_dn_rd3) begin
         if (h_rd < rsel) begin m_ff <= rchild; lv_ff <= h_rd; end
      end
      if (cmd.hp_dn_sw) pos_ff <= m_ff;
      if (cmd.score) prod_ff <= BW'(sum_ff * cur_ff[PW-1:ValueBits]);
      if (cmd.accum && prod_ff > best_ff) best_ff <= prod_ff;
      if (cmd.next_i) i_ff <= i_ff + CW'(1);
      if (cmd.emit) begin
         score     <= sts.bad ? '0 : ScoreBits'(best_ff);
         bad_count <= sts.bad;
      end
   end

   logic [ValueBits-1:0] rsel;
   assign rsel = (m_ff == pos_ff) ? w_ff : lv_ff;

   always_comb begin
      sts           = '0;
      sts.bad       = (keep_count == '0) || (KW'(keep_count) > KW'(count_ff));
      sts.full      = full;
      sts.sort_more = i_ff < count_ff;
      sts.shift_go  = (j_ff != '0) && (s_rd < cur_ff);
      sts.scan_more = i_ff < count_ff;
      sts.heap_fill = hsize_ff < kext;
      sts.up_top    = pos_ff == '0;
      sts.up_go     = h_rd > w_ff;
      sts.dn_has_l  = lchild < hsize_ff;
      sts.dn_has_r  = rchild < hsize_ff;
      sts.dn_go     = m_ff != pos_ff;
      sts.at_k      = hsize_ff == kext;
   end
endmodule

// File: hw/rtl/tksm_ctrl.sv
// Controller state machine: load, insertion sort, heap scan, result strobe.
// Depends on tksm_pkg.
module tksm_ctrl import tksm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         last_item,
   input  tksm_sts_type sts,
   output tksm_cmd_type cmd,
   output logic         busy,
   output logic         rsp_valid
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_SRT0 = 5'd1,  S_SRT1 = 5'd2,
                          S_SRTJ = 5'd3,  S_SRTW = 5'd4,  S_SCN0 = 5'd5,
                          S_SCN1 = 5'd6,  S_SCN2 = 5'd7,  S_UPR  = 5'd8,
                          S_UPC  = 5'd9,  S_REP  = 5'd10, S_DNL  = 5'd11,
                          S_DNR  = 5'd12, S_DNC  = 5'd13, S_MUL  = 5'd14,
                          S_ACC  = 5'd15, S_EMIT = 5'd16, S_OUT  = 5'd17,
                          S_SRTR = 5'd18, S_SRTC = 5'd19, S_DNW  = 5'd20;
   logic [4:0] state_ff, state_in;
   logic       valid_ff;

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd = '0; state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            if (last_item) state_in = S_SRT0;
         end
         S_SRT0: begin  // check bad count; then sort from i = 1
            cmd.scan_init = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: state_in = sts.bad ? S_OUT : S_SRTC;
         S_SRTC: begin cmd.next_i = 1'b1; state_in = S_SRT1; end
         S_SRT1: if (sts.sort_more) begin cmd.init_i = 1'b1; state_in = S_SRTR; end
                 else begin cmd.scan_init = 1'b1; state_in = S_SCN0; end
         S_SRTR: begin cmd.sort_cur = 1'b1; state_in = S_SRTJ; end
         S_SRTJ: begin cmd.sort_rd = 1'b1; state_in = S_SRTW; end
         S_SRTW: if (sts.shift_go) begin cmd.shift_wr = 1'b1; state_in = S_SRTJ; end
                 else begin cmd.place_wr = 1'b1; state_in = S_SRT1; end
         S_SCN0: if (sts.scan_more) state_in = S_SCN1;
                 else state_in = S_OUT;
         S_SCN1: begin cmd.scan_rd = 1'b1; state_in = S_SCN2; end
         S_SCN2: if (sts.heap_fill) begin cmd.hp_push = 1'b1; state_in = S_UPR; end
                 else state_in = S_REP;
         S_UPR:  begin
            cmd.hp_put = 1'b1;
            if (sts.up_top) state_in = S_MUL;
            else begin cmd.hp_up_rd = 1'b1; state_in = S_UPC; end
         end
         S_UPC:  if (sts.up_go) begin cmd.hp_up_sw = 1'b1; state_in = S_UPR; end
                 else state_in = S_MUL;
         S_REP:  begin cmd.hp_rep = 1'b1; state_in = S_DNL; end
         S_DNL:  begin
            cmd.hp_put = 1'b1;
            if (sts.dn_has_l) begin cmd.hp_dn_rd = 1'b1; state_in = S_DNR; end
            else state_in = S_MUL;
         end
         S_DNR:  begin
            cmd.hp_dn_rd2 = 1'b1;
            state_in = sts.dn_has_r ? S_DNW : S_DNC;
         end
         S_DNW:  begin cmd.hp_dn_rd3 = 1'b1; state_in = S_DNC; end
         S_DNC:  if (sts.dn_go) begin cmd.hp_dn_sw = 1'b1; state_in = S_DNL; end
                 else state_in = S_MUL;
         S_MUL:  begin if (sts.at_k) cmd.score = 1'b1; state_in = S_ACC; end
         S_ACC:  begin
            if (sts.at_k) cmd.accum = 1'b1;
            cmd.next_i = 1'b1; state_in = S_SCN0;
         end
         S_OUT:  begin cmd.emit = 1'b1; cmd.clr_count = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= cmd.emit;
      end
   end
endmodule

// File: hw/rtl/top_k_sum_times_min_key_score_top.sv
// Top-k sum times min key score engine, top level.
// Pairs load while idle; after the marked item, an insertion sort on the store
// port and then a heap scan on the heap port.
// A bad keep_count skips both: the controller goes from S_EMIT to S_OUT and the strobe.
// Throughput: one set at a time; busy is high from the marked item until the strobe.
// Reset clears control and counts; keep_count resets to 1. Results cannot stall.
module top_k_sum_times_min_key_score_top import tksm_pkg::*; #(
   parameter int MaxPairs  = MaxPairsDefault,
   parameter int ValueBits = ValueBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ValueBits-1:0] req_weight,
   input  logic [ValueBits-1:0] req_key,
   input  logic                 req_last_item,
   output logic                 rsp_valid,
   output logic [ScoreBits-1:0] rsp_score,
   output logic                 rsp_bad_count,
   input  logic                 csr_we,
   input  logic [CountBits-1:0] csr_wdata
);
   tksm_cmd_type cmd;
   tksm_sts_type sts;
   logic [CountBits-1:0] keep_ff;

   always_ff @(posedge clock) begin
      if (reset) keep_ff <= CountBits'(1);
      else if (csr_we) keep_ff <= csr_wdata;
   end

   tksm_ctrl u_ctrl (
      .clock, .reset, .start, .last_item(req_last_item), .sts, .cmd, .busy, .rsp_valid);

   tksm_datapath #(.MaxPairs(MaxPairs), .ValueBits(ValueBits)) u_dp (
      .clock, .reset, .cmd, .sts, .weight(req_weight), .key(req_key),
      .keep_count(keep_ff), .score(rsp_score), .bad_count(rsp_bad_count));
endmodule

// File: tb/sv/tksm_checker.sv
// Checker for the top-k sum times min key score engine: watches both channels,
// predicts each set's score and compares it with the block's result.
// Depends on tksm_pkg for field widths.
module tksm_checker import tksm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [15:0]          req_weight,
   input  logic [15:0]          req_key,
   input  logic                 req_last_item,
   input  logic                 rsp_valid,
   input  logic [ScoreBits-1:0] rsp_score,
   input  logic                 rsp_bad_count,
   input  logic                 csr_we,
   input  logic [CountBits-1:0] csr_wdata,
   output int                   fail_count,
   output int                   scores_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StoreDepth = 1024;

   typedef struct {
      logic [ScoreBits-1:0] score;
      logic                 bad;
   } set_score_type;

   logic [CountBits-1:0] keep_count;
   logic [31:0]          set_pairs[$];
   set_score_type        score_q[$];

   assign scores_pending = score_q.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic set_score_type score_of_set();
      logic [31:0]   sorted[$];
      logic [15:0]   chosen[$];
      set_score_type res;
      longint        sum, prod, best;
      int            idx;
      logic [15:0]   w;
      res.score = '0;
      res.bad   = 1'b0;
      if (keep_count == 0 || keep_count > set_pairs.size()) begin
         res.bad = 1'b1;
         return res;
      end
      // descending by packed key:weight
      foreach (set_pairs[p]) begin
         idx = 0;
         while (idx < sorted.size() && sorted[idx] >= set_pairs[p]) idx++;
         sorted.insert(idx, set_pairs[p]);
      end
      sum  = 0;
      best = 0;
      foreach (sorted[i]) begin
         w = sorted[i][15:0];
         // a full heap always trades its smallest weight for the new one
         if (chosen.size() >= keep_count) begin
            sum -= chosen[0];
            void'(chosen.pop_front());
         end
         idx = 0;
         while (idx < chosen.size() && chosen[idx] < w) idx++;
         chosen.insert(idx, w);
         sum += w;
         if (chosen.size() == keep_count) begin
            prod = sum * longint'(sorted[i][31:16]);
            if (prod > best) best = prod;
         end
      end
      res.score = best[ScoreBits-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      set_score_type want;
      if (reset) begin
         keep_count = CountBits'(1);
         set_pairs.delete();
         score_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) keep_count = csr_wdata;
         if (start && !busy) begin
            if (set_pairs.size() < StoreDepth)
               set_pairs.insert(set_pairs.size(), {req_key, req_weight});
            if (req_last_item) begin
               score_q.insert(score_q.size(), score_of_set());
               set_pairs.delete();
            end
         end
         if (rsp_valid) begin
            if (score_q.size() == 0) begin
               report("unexpected result", rsp_score, 0);
            end else begin
               want = score_q.pop_front();
               if (rsp_score !== want.score) report("score", rsp_score, want.score);
               if (rsp_bad_count !== want.bad) report("bad_count", rsp_bad_count, want.bad);
            end
         end
      end
   end

   final begin
      if (score_q.size() != 0) $display("mismatch: %0d results never came", score_q.size());
   end
endmodule

// File: tb/sv/tb_top_k_sum_times_min_key_score_top.sv
// Testbench top for the top-k sum times min key score engine: drives sets of
// pairs and keep_count settings; tksm_checker predicts and compares.
// Depends on tksm_pkg, top_k_sum_times_min_key_score_top and tksm_checker.
module tb_top_k_sum_times_min_key_score_top;
   import tksm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [15:0]          req_weight = '0;
   logic [15:0]          req_key = '0;
   logic                 req_last_item = 1'b0;
   logic                 rsp_valid;
   logic [ScoreBits-1:0] rsp_score;
   logic                 rsp_bad_count;
   logic                 csr_we = 1'b0;
   logic [CountBits-1:0] csr_wdata = '0;
   int                   fail_count;
   int                   scores_pending;
   int                   quiet_cycles = 0;
   bit                   steady = 1'b0;
   int                   items_sent = 0;

   always #5 clock = ~clock;

   top_k_sum_times_min_key_score_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_weight(req_weight), .req_key(req_key), .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_score(rsp_score), .rsp_bad_count(rsp_bad_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   tksm_checker u_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_weight(req_weight), .req_key(req_key), .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_score(rsp_score), .rsp_bad_count(rsp_bad_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .scores_pending(scores_pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_pair(input logic [15:0] w, input logic [15:0] k, input logic last);
      if (!steady) begin
         while ($urandom_range(99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clock);
         end
      end
      start         <= 1'b1;
      req_weight    <= w;
      req_key       <= k;
      req_last_item <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every result is in, plus some margin
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (scores_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_keep(input logic [CountBits-1:0] k);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= k;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(8));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_set(input int len);
      for (int i = 0; i < len; i++) send_pair(pick_value(), pick_value(), i == len - 1);
   endtask

   initial begin
      int len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: keep_count of one after reset, extremes, ties, bad counts
      send_pair(16'hffff, 16'hffff, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b1);
      write_keep(CountBits'(2));
      send_pair(16'd10, 16'd5, 1'b0);
      send_pair(16'd20, 16'd5, 1'b0);
      send_pair(16'd3, 16'd9, 1'b0);
      send_pair(16'd3, 16'd9, 1'b0);
      send_pair(16'hffff, 16'd1, 1'b0);
      send_pair(16'd7, 16'hffff, 1'b1);
      send_pair(16'd4, 16'd4, 1'b1);
      write_keep(CountBits'(0));
      send_pair(16'd1, 16'd1, 1'b0);
      send_pair(16'd2, 16'd2, 1'b1);
      write_keep(CountBits'(3));
      send_pair(16'd1, 16'd1, 1'b0);
      send_pair(16'd2, 16'd2, 1'b1);

      // fill the store past its depth; descending keys keep the sort short
      write_keep(CountBits'(1024));
      steady = 1'b1;
      for (int i = 0; i < 1030; i++)
         send_pair(16'($urandom), 16'(16'hffff - i), i == 1029);
      steady = 1'b0;
      write_keep(CountBits'(1023));
      send_set(3);

      // random sets, mostly short with small keep_count
      while (items_sent < 1250) begin
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(9))
               0: write_keep(CountBits'(0));
               1: write_keep(CountBits'(1));
               2: write_keep(CountBits'(1024));
               default: write_keep(CountBits'($urandom_range(5, 1)));
            endcase
         end
         steady = (items_sent > 1120 && items_sent < 1200);
         len = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(10, 1);
         send_set(len);
      end
      steady = 1'b0;

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && scores_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
